/* hw/rtl/krt_pkg.sv */
// Shared types and constants for the keyed registration table.
// Used by the channel interfaces, the sequencer and the top level.
// Has no dependencies.
package krt_pkg;

   localparam int CAPACITY = 32;
   localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   localparam int CMD_W = 2;
   localparam int KEY_W = 32;
   localparam int HANDLE_W = 16;
   localparam int STATUS_W = 2;
   localparam int COUNT_OUT_W = 6;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOOKUP = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_REMOVE = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_NOT_FOUND = 2'd1,
      STAT_DUPLICATE = 2'd2,
      STAT_FULL      = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_CMP,
      S_MOVE_RD,
      S_MOVE_WR,
      S_RESP
   } state_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [ADDR_W-1:0] rd_addr;
   } mem_ctrl_type;

endpackage

/* hw/rtl/krt_req_if.sv */
// Request channel of the keyed registration table: valid, ready and one command word.
// Depends on krt_pkg for the field widths.
interface krt_req_if;
   logic                         valid;
   logic                         ready;
   logic [krt_pkg::CMD_W-1:0]    command;
   logic [krt_pkg::KEY_W-1:0]    client_key;
   logic [krt_pkg::HANDLE_W-1:0] client_handle;

   modport source(output valid, output command, output client_key, output client_handle,
                  input ready);
   modport sink(input valid, input command, input client_key, input client_handle,
                output ready);
endinterface

/* hw/rtl/krt_rsp_if.sv */
// Response channel of the keyed registration table: valid, ready and one result word.
// Depends on krt_pkg for the field widths.
interface krt_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [krt_pkg::STATUS_W-1:0]    status;
   logic [krt_pkg::HANDLE_W-1:0]    found_handle;
   logic [krt_pkg::COUNT_OUT_W-1:0] entry_count;

   modport source(output valid, output status, output found_handle, output entry_count,
                  input ready);
   modport sink(input valid, input status, input found_handle, input entry_count,
                output ready);
endinterface

/* hw/rtl/krt_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module krt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/krt_seq.sv */
// Sequencer of the keyed registration table: scans the stores one slot at a time through
// a single key comparator, then appends, moves or reports. Depends on krt_pkg and the
// channel interfaces.
module krt_seq (
   input  logic                           clock,
   input  logic                           reset,
   krt_req_if.sink                        req_if,
   krt_rsp_if.source                      rsp_if,
   output krt_pkg::mem_ctrl_type          mem,
   output logic [krt_pkg::KEY_W-1:0]      key_wdata,
   output logic [krt_pkg::HANDLE_W-1:0]   handle_wdata,
   input  logic [krt_pkg::KEY_W-1:0]      key_rdata,
   input  logic [krt_pkg::HANDLE_W-1:0]   handle_rdata
);

   krt_pkg::state_type             state_ff, state_in;
   logic [krt_pkg::CNT_W-1:0]      idx_ff, idx_in;
   logic [krt_pkg::CNT_W-1:0]      count_ff, count_in;
   logic [krt_pkg::CMD_W-1:0]      cmd_ff, cmd_in;
   logic [krt_pkg::KEY_W-1:0]      key_ff, key_in;
   logic [krt_pkg::HANDLE_W-1:0]   handle_ff, handle_in;
   krt_pkg::status_type            status_ff, status_in;
   logic [krt_pkg::HANDLE_W-1:0]   found_ff, found_in;

   logic                           accept;
   logic                           scan_end;
   logic                           key_match;
   logic                           is_full;
   logic                           at_last;
   logic [krt_pkg::CNT_W-1:0]      last_idx;

   assign accept    = req_if.valid && (state_ff == krt_pkg::S_IDLE);
   assign scan_end  = (idx_ff == count_ff);
   assign key_match = (key_rdata == key_ff);
   assign is_full   = (count_ff >= krt_pkg::CNT_W'(krt_pkg::CAPACITY));
   assign last_idx  = krt_pkg::CNT_W'(count_ff - krt_pkg::CNT_W'(1));
   assign at_last   = (idx_ff == last_idx);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         krt_pkg::S_IDLE: begin
            if (accept) begin
               if (req_if.command == krt_pkg::CMD_LOOKUP ||
                   req_if.command == krt_pkg::CMD_INSERT ||
                   req_if.command == krt_pkg::CMD_REMOVE) begin
                  state_in = krt_pkg::S_SCAN;
               end else begin
                  state_in = krt_pkg::S_RESP;
               end
            end
         end
         krt_pkg::S_SCAN: begin
            state_in = scan_end ? krt_pkg::S_RESP : krt_pkg::S_CMP;
         end
         krt_pkg::S_CMP: begin
            if (!key_match) begin
               state_in = krt_pkg::S_SCAN;
            end else if (cmd_ff == krt_pkg::CMD_REMOVE && !at_last) begin
               state_in = krt_pkg::S_MOVE_RD;
            end else begin
               state_in = krt_pkg::S_RESP;
            end
         end
         krt_pkg::S_MOVE_RD: state_in = krt_pkg::S_MOVE_WR;
         krt_pkg::S_MOVE_WR: state_in = krt_pkg::S_RESP;
         krt_pkg::S_RESP: begin
            if (rsp_if.ready) begin
               state_in = krt_pkg::S_IDLE;
            end
         end
         default: state_in = krt_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      req_if.ready = (state_ff == krt_pkg::S_IDLE);
      rsp_if.valid = (state_ff == krt_pkg::S_RESP);
      mem.wr_en    = 1'b0;
      mem.wr_addr  = idx_ff[krt_pkg::ADDR_W-1:0];
      mem.rd_addr  = idx_ff[krt_pkg::ADDR_W-1:0];
      key_wdata    = key_rdata;
      handle_wdata = handle_rdata;
      unique case (state_ff)
         krt_pkg::S_SCAN: begin
            if (scan_end && cmd_ff == krt_pkg::CMD_INSERT && !is_full) begin
               mem.wr_en    = 1'b1;
               mem.wr_addr  = count_ff[krt_pkg::ADDR_W-1:0];
               key_wdata    = key_ff;
               handle_wdata = handle_ff;
            end
         end
         krt_pkg::S_MOVE_RD: mem.rd_addr = last_idx[krt_pkg::ADDR_W-1:0];
         krt_pkg::S_MOVE_WR: mem.wr_en = 1'b1;
         default: ;
      endcase
   end

   always_comb begin
      idx_in    = idx_ff;
      count_in  = count_ff;
      cmd_in    = cmd_ff;
      key_in    = key_ff;
      handle_in = handle_ff;
      status_in = status_ff;
      found_in  = found_ff;
      unique case (state_ff)
         krt_pkg::S_IDLE: begin
            if (accept) begin
               idx_in    = '0;
               cmd_in    = req_if.command;
               key_in    = req_if.client_key;
               handle_in = req_if.client_handle;
               status_in = krt_pkg::STAT_NOT_FOUND;
               found_in  = '0;
            end
         end
         krt_pkg::S_SCAN: begin
            if (scan_end && cmd_ff == krt_pkg::CMD_INSERT) begin
               if (is_full) begin
                  status_in = krt_pkg::STAT_FULL;
               end else begin
                  status_in = krt_pkg::STAT_OK;
                  count_in  = krt_pkg::CNT_W'(count_ff + krt_pkg::CNT_W'(1));
               end
            end
         end
         krt_pkg::S_CMP: begin
            if (key_match) begin
               if (cmd_ff == krt_pkg::CMD_INSERT) begin
                  status_in = krt_pkg::STAT_DUPLICATE;
               end else begin
                  status_in = krt_pkg::STAT_OK;
                  found_in  = handle_rdata;
                  if (cmd_ff == krt_pkg::CMD_REMOVE && at_last) begin
                     count_in = last_idx;
                  end
               end
            end else begin
               idx_in = krt_pkg::CNT_W'(idx_ff + krt_pkg::CNT_W'(1));
            end
         end
         krt_pkg::S_MOVE_WR: count_in = last_idx;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= krt_pkg::S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      idx_ff    <= idx_in;
      cmd_ff    <= cmd_in;
      key_ff    <= key_in;
      handle_ff <= handle_in;
      status_ff <= status_in;
      found_ff  <= found_in;
   end

   assign rsp_if.status       = status_ff;
   assign rsp_if.found_handle = found_ff;
   assign rsp_if.entry_count  = krt_pkg::COUNT_OUT_W'(count_ff);

endmodule

/* hw/rtl/keyed_registration_table.sv */
// Top level of the keyed registration table: key and handle stores plus the sequencer.
// Depends on krt_pkg, krt_req_if, krt_rsp_if, krt_ram and krt_seq.
//
// The request channel carries a command word (lookup, insert or remove), a 32-bit key
// and a 16-bit handle. The response channel returns one word per request: a status,
// the handle found or removed, and the entry count after the operation.
// Entries stay packed in slots 0 to n-1, where n is the entry count. One key comparator
// walks the slots in order, and each slot passes through a scan and a compare state
// because the key RAM has a registered read. A hit ends the walk at its slot; a miss,
// as in any insert that is not a duplicate, walks all n slots. A remove that moves
// the last entry into the freed slot adds a move-read and a move-write state. An unused
// command code goes straight to the response without a scan. Only one request is in
// flight; the request side is not ready again until the response word has been taken.
// Reset empties the table at once; no clearing pass runs and the stores are not cleared.
// While the receiver stalls, the response word holds and no new request is accepted.
module keyed_registration_table (
   input logic       clock,
   input logic       reset,
   krt_req_if.sink   req_if,
   krt_rsp_if.source rsp_if
);

   krt_pkg::mem_ctrl_type          mem;
   logic [krt_pkg::KEY_W-1:0]      key_wdata;
   logic [krt_pkg::KEY_W-1:0]      key_rdata;
   logic [krt_pkg::HANDLE_W-1:0]   handle_wdata;
   logic [krt_pkg::HANDLE_W-1:0]   handle_rdata;

   krt_ram #(
      .WIDTH(krt_pkg::KEY_W),
      .DEPTH(krt_pkg::CAPACITY)
   ) u_key_ram (
      .clock  (clock),
      .wr_en  (mem.wr_en),
      .wr_addr(mem.wr_addr),
      .wr_data(key_wdata),
      .rd_addr(mem.rd_addr),
      .rd_data(key_rdata)
   );

   krt_ram #(
      .WIDTH(krt_pkg::HANDLE_W),
      .DEPTH(krt_pkg::CAPACITY)
   ) u_handle_ram (
      .clock  (clock),
      .wr_en  (mem.wr_en),
      .wr_addr(mem.wr_addr),
      .wr_data(handle_wdata),
      .rd_addr(mem.rd_addr),
      .rd_data(handle_rdata)
   );

   krt_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .mem         (mem),
      .key_wdata   (key_wdata),
      .handle_wdata(handle_wdata),
      .key_rdata   (key_rdata),
      .handle_rdata(handle_rdata)
   );

`ifndef SYNTH
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(req_if.ready && rsp_if.valid))
      else $error("request side ready while a response word is pending");

   a_ready_after_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.ready) |=> req_if.ready)
      else $error("request side not ready after the response word was taken");

   a_no_write_when_idle: assert property (@(posedge clock) disable iff (reset)
      mem.wr_en |-> (!req_if.ready && !rsp_if.valid))
      else $error("store written outside of an operation");

   a_handle_only_on_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.found_handle != '0) |-> (rsp_if.status == krt_pkg::STAT_OK))
      else $error("nonzero handle returned with a failing status");
`endif

endmodule

/* test/krt_table_monitor.sv */
// Watches the request and response channels of the keyed registration table, keeps its own
// copy of the key/handle table to predict each response word, and counts mismatches.
// Depends on krt_pkg, krt_req_if and krt_rsp_if.
module krt_table_monitor (
   input  logic clock,
   input  logic reset,
   krt_req_if   req_bus,
   krt_rsp_if   rsp_bus,
   output int   failures,
   output int   outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      krt_pkg::status_type                 status;
      logic [krt_pkg::HANDLE_W-1:0]        handle;
      logic [krt_pkg::COUNT_OUT_W-1:0]     count;
   } table_result_type;

   table_result_type             expected_q[$];
   logic [krt_pkg::KEY_W-1:0]    slot_keys[krt_pkg::CAPACITY];
   logic [krt_pkg::HANDLE_W-1:0] slot_handles[krt_pkg::CAPACITY];
   int unsigned                  used_slots;

   function automatic table_result_type apply_command(
         input logic [krt_pkg::CMD_W-1:0] cmd,
         input logic [krt_pkg::KEY_W-1:0] key,
         input logic [krt_pkg::HANDLE_W-1:0] handle);
      table_result_type r;
      int unsigned      slot;
      bit               hit;
      slot = used_slots;
      for (int unsigned i = 0; i < used_slots; i++) begin
         if (slot_keys[i] == key && slot == used_slots) begin
            slot = i;
         end
      end
      hit = slot < used_slots;
      r.status = krt_pkg::STAT_NOT_FOUND;
      r.handle = '0;
      unique case (cmd)
         krt_pkg::CMD_LOOKUP: begin
            if (hit) begin
               r.status = krt_pkg::STAT_OK;
               r.handle = slot_handles[slot];
            end
         end
         krt_pkg::CMD_INSERT: begin
            if (hit) begin
               r.status = krt_pkg::STAT_DUPLICATE;
            end else if (used_slots >= krt_pkg::CAPACITY) begin
               r.status = krt_pkg::STAT_FULL;
            end else begin
               slot_keys[used_slots] = key;
               slot_handles[used_slots] = handle;
               used_slots++;
               r.status = krt_pkg::STAT_OK;
            end
         end
         krt_pkg::CMD_REMOVE: begin
            if (hit) begin
               r.handle = slot_handles[slot];
               slot_keys[slot] = slot_keys[used_slots - 1];
               slot_handles[slot] = slot_handles[used_slots - 1];
               used_slots--;
               r.status = krt_pkg::STAT_OK;
            end
         end
         default: ;
      endcase
      r.count = krt_pkg::COUNT_OUT_W'(used_slots);
      return r;
   endfunction

   always @(posedge clock) begin
      table_result_type want;
      int errs;
      if (reset) begin
         expected_q.delete();
         used_slots = 0;
         failures <= 0;
         outstanding <= 0;
      end else begin
         errs = 0;
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected response word status %0d handle %h count %0d",
                        $time, rsp_bus.status, rsp_bus.found_handle, rsp_bus.entry_count);
               errs++;
            end else begin
               want = expected_q.pop_front();
               if (rsp_bus.status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, rsp_bus.status);
                  errs++;
               end
               if (rsp_bus.found_handle !== want.handle) begin
                  $display("%0t: found_handle expected %h actual %h",
                           $time, want.handle, rsp_bus.found_handle);
                  errs++;
               end
               if (rsp_bus.entry_count !== want.count) begin
                  $display("%0t: entry_count expected %0d actual %0d",
                           $time, want.count, rsp_bus.entry_count);
                  errs++;
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            expected_q.push_back(apply_command(req_bus.command, req_bus.client_key,
                                               req_bus.client_handle));
         end
         failures <= failures + errs;
         outstanding <= expected_q.size();
      end
   end

endmodule

/* test/tb_keyed_registration_table.sv */
// Top of the keyed registration table testbench: clock, reset, request words and response pacing.
// Depends on krt_pkg, krt_req_if, krt_rsp_if, keyed_registration_table and krt_table_monitor.
module tb_keyed_registration_table;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [krt_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int TIMEOUT_CYCLES = 1_000_000;
   localparam int KEY_POOL = 40;
   localparam int PHASES = 12;
   localparam int PHASE_ITEMS = 86;
   localparam int LONG_HOLD_AT = 3000;
   localparam int LONG_HOLD_CYCLES = 400;

   logic clock = 1'b0;
   logic reset;
   int   failures;
   int   outstanding;
   int   cycle_count = 0;
   bit   sender_steady;
   logic [krt_pkg::KEY_W-1:0] key_pool[KEY_POOL];

   krt_req_if req_bus();
   krt_rsp_if rsp_bus();

   keyed_registration_table dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_bus),
      .rsp_if(rsp_bus)
   );

   krt_table_monitor table_monitor (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .failures   (failures),
      .outstanding(outstanding)
   );

   always #5ns clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == TIMEOUT_CYCLES) begin
         $display("keyed_registration_table: mismatch");
         $finish;
      end
   end

   function automatic int idle_length();
      int r;
      r = $urandom_range(99);
      if (r < 60) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(3, 1);
      end
      return $urandom_range(40, 10);
   endfunction

   task automatic send_word(input logic [krt_pkg::CMD_W-1:0] cmd,
                            input logic [krt_pkg::KEY_W-1:0] key,
                            input logic [krt_pkg::HANDLE_W-1:0] handle);
      int gap;
      req_bus.valid <= 1'b1;
      req_bus.command <= cmd;
      req_bus.client_key <= key;
      req_bus.client_handle <= handle;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      gap = sender_steady ? 0 : idle_length();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_all_answered();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   initial begin : response_pacing
      int hold;
      int cycle_no;
      bit steady;
      hold = 0;
      cycle_no = 0;
      steady = 1'b0;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         cycle_no++;
         if (cycle_no % 150 == 0) begin
            steady = ($urandom_range(3) == 0);
         end
         if (cycle_no == LONG_HOLD_AT) begin
            hold = LONG_HOLD_CYCLES;
         end
         if (hold > 0) begin
            rsp_bus.ready <= 1'b0;
            hold--;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (!steady && $urandom_range(99) < 25) begin
               hold = idle_length();
            end
         end
         @(posedge clock);
      end
   end

   initial begin : stimulus
      logic [krt_pkg::CMD_W-1:0] cmd;
      logic [krt_pkg::KEY_W-1:0] key;
      int ins_pct;
      int rem_pct;
      int r;
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.command <= krt_pkg::CMD_LOOKUP;
      req_bus.client_key <= '0;
      req_bus.client_handle <= '0;
      sender_steady = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_word(krt_pkg::CMD_LOOKUP, 32'h0000_0000, 16'h0000);
      send_word(krt_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 16'hFFFF);
      send_word(CMD_UNUSED, 32'hFFFF_FFFF, 16'hFFFF);
      send_word(krt_pkg::CMD_INSERT, 32'h0000_0000, 16'hFFFF);
      send_word(krt_pkg::CMD_INSERT, 32'hFFFF_FFFF, 16'h0000);
      send_word(krt_pkg::CMD_INSERT, 32'h0000_0000, 16'h1234);
      send_word(krt_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 16'hFFFF);
      send_word(krt_pkg::CMD_LOOKUP, 32'h0000_0000, 16'h0000);
      send_word(krt_pkg::CMD_INSERT, 32'hA5A5_5A5A, 16'h5A5A);
      send_word(krt_pkg::CMD_INSERT, 32'h5A5A_A5A5, 16'hA5A5);
      send_word(krt_pkg::CMD_REMOVE, 32'h0000_0000, 16'h0000);
      send_word(krt_pkg::CMD_LOOKUP, 32'h5A5A_A5A5, 16'h0000);
      send_word(krt_pkg::CMD_REMOVE, 32'hA5A5_5A5A, 16'h0000);
      send_word(CMD_UNUSED, 32'h5A5A_A5A5, 16'h0000);
      send_word(krt_pkg::CMD_LOOKUP, 32'hA5A5_5A5A, 16'h0000);
      send_word(krt_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 16'h0000);
      send_word(krt_pkg::CMD_REMOVE, 32'h5A5A_A5A5, 16'h0000);
      send_word(krt_pkg::CMD_LOOKUP, 32'h0000_0000, 16'h0000);

      // Keys come mostly from a small pool so that lookups and removes hit and inserts
      // can fill the table; fill, mixed and drain phases alternate.
      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase % 4 == 0) begin
            foreach (key_pool[i]) key_pool[i] = $urandom();
         end
         if (phase % 2 == 1) begin
            wait_all_answered();
         end
         sender_steady = (phase % 3 == 2);
         unique case (phase % 4)
            0: begin ins_pct = 75; rem_pct = 5; end
            1: begin ins_pct = 35; rem_pct = 30; end
            2: begin ins_pct = 10; rem_pct = 70; end
            default: begin ins_pct = 20; rem_pct = 20; end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            r = $urandom_range(99);
            if (r < 3) begin
               cmd = CMD_UNUSED;
            end else if (r < 3 + ins_pct) begin
               cmd = krt_pkg::CMD_INSERT;
            end else if (r < 3 + ins_pct + rem_pct) begin
               cmd = krt_pkg::CMD_REMOVE;
            end else begin
               cmd = krt_pkg::CMD_LOOKUP;
            end
            key = ($urandom_range(9) == 0) ? $urandom() : key_pool[$urandom_range(KEY_POOL - 1)];
            send_word(cmd, key, krt_pkg::HANDLE_W'($urandom()));
         end
      end

      wait_all_answered();
      repeat (10) @(posedge clock);
      if (failures == 0) begin
         $display("keyed_registration_table: match");
      end else begin
         $display("keyed_registration_table: mismatch");
      end
      $finish;
   end

endmodule

/* files.f */
hw/rtl/krt_pkg.sv
hw/rtl/krt_req_if.sv
hw/rtl/krt_rsp_if.sv
hw/rtl/krt_ram.sv
hw/rtl/krt_seq.sv
hw/rtl/keyed_registration_table.sv
test/krt_table_monitor.sv
test/tb_keyed_registration_table.sv
